### design/rbs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbs_pkg
// Shared widths, register codes and blend helpers for the RGB565 bilinear
// scaler.
// ----------------------------------------------------------------------------
package rbs_pkg;

	localparam int PIX_W   = 16;  // rgb565 word
	localparam int POS_W   = 12;  // column / row of an item
	localparam int CROP_W  = 8;   // crop size registers
	localparam int OUT_W   = 13;  // output size registers
	localparam int CFG_W   = 13;  // config data, widest register
	localparam int FRAC_W  = 16;  // fraction bits of a 16.16 position
	localparam int STEP_W  = CROP_W + FRAC_W; // step never exceeds (255 - 2) << 16
	localparam int CNT_W   = $clog2(STEP_W);
	localparam int WGT_W   = 7;   // weight taken from position bits 15:9
	localparam int WGT_LSB = 9;
	localparam int TOP_W   = 13;  // first blend pass, up to 63 * 128
	localparam int SUM_W   = 21;  // second blend pass before the shift
	localparam int BLEND_SHIFT = 14;

	localparam logic [CROP_W-1:0] CROP_MIN = 8'd2;
	localparam logic [7:0]        WGT_ONE  = 8'd128;

	typedef enum logic [1:0] {
		REG_CROP_W = 2'd0,
		REG_CROP_H = 2'd1,
		REG_OUT_W  = 2'd2,
		REG_OUT_H  = 2'd3
	} cfg_reg_t;

	// a * wa + b * wb, one colour field against a weight pair
	function automatic logic [TOP_W-1:0] lerp_h(input logic [5:0] a, input logic [5:0] b,
	                                            input logic [7:0] wa, input logic [7:0] wb);
		logic [TOP_W:0] pa;
		logic [TOP_W:0] pb;
		logic [TOP_W:0] s;
		pa = {8'b0, a} * {6'b0, wa};
		pb = {8'b0, b} * {6'b0, wb};
		s  = pa + pb;
		return s[TOP_W-1:0];
	endfunction

	// (t * wa + b * wb) >> 14, truncating
	function automatic logic [5:0] lerp_v(input logic [TOP_W-1:0] t,
	                                      input logic [TOP_W-1:0] b,
	                                      input logic [7:0] wa, input logic [7:0] wb);
		logic [SUM_W-1:0] pa;
		logic [SUM_W-1:0] pb;
		logic [SUM_W-1:0] s;
		pa = {8'b0, t} * {13'b0, wa};
		pb = {8'b0, b} * {13'b0, wb};
		s  = pa + pb;
		return s[BLEND_SHIFT+5:BLEND_SHIFT];
	endfunction

endpackage

### design/rgb565_bilinear_scaler_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb565_bilinear_scaler_top
// Bilinear scaler for RGB565 images: loads fill a frame store, queries
// return one interpolated pixel each through a seven stage pipeline.
// ----------------------------------------------------------------------------
//
//  channel   handshake           payload                         dir
//  -------   ---------           -------                         ---
//  item      start / busy        mode, pos_x, pos_y, pixel_in    in
//  result    pixel_valid         pixel_out                       out
//  config    cfg_we              cfg_idx, cfg_data               in
//
//  - one item is taken per cycle while busy is low; a query beat returns
//    its pixel through stages 1 to 7, a load beat returns nothing
//  - busy is high after reset and after every config write, while a
//    radix-2 divider forms both 8.16 steps, one quotient bit per cycle
//  - the frame store is split by address parity into two banks with two
//    read ports each, so the four neighbors are read in the same cycle
//  - reset clears control and config registers only; store contents are
//    undefined until loaded
//  - the receiver cannot stall, so the pipeline never holds
//
module rgb565_bilinear_scaler_top #(
	parameter int MAX_SRC_WIDTH  = 128,
	parameter int MAX_SRC_HEIGHT = 128
) (
	input  logic                       clk,
	input  logic                       arst_n,
	// item beat
	input  logic                       start,
	output logic                       busy,
	input  logic                       mode,
	input  logic [rbs_pkg::POS_W-1:0]  pos_x,
	input  logic [rbs_pkg::POS_W-1:0]  pos_y,
	input  logic [rbs_pkg::PIX_W-1:0]  pixel_in,
	// result beat
	output logic                       pixel_valid,
	output logic [rbs_pkg::PIX_W-1:0]  pixel_out,
	// config write
	input  logic                       cfg_we,
	input  rbs_pkg::cfg_reg_t          cfg_idx,
	input  logic [rbs_pkg::CFG_W-1:0]  cfg_data
);
	import rbs_pkg::*;

	// store geometry: linear address row * crop_width + col
	localparam int DEPTH   = MAX_SRC_WIDTH * MAX_SRC_HEIGHT;
	localparam int AW      = $clog2(DEPTH);
	localparam int BI_W    = AW - 1;
	localparam int BANK_D  = (DEPTH + 1) / 2;
	localparam int CWMAX_I = (MAX_SRC_WIDTH > 255) ? 255 : MAX_SRC_WIDTH;
	localparam int CHMAX_I = (MAX_SRC_HEIGHT > 255) ? 255 : MAX_SRC_HEIGHT;
	localparam logic [CROP_W-1:0] CW_MAX = CROP_W'(CWMAX_I);
	localparam logic [CROP_W-1:0] CH_MAX = CROP_W'(CHMAX_I);

	// ------------------------------------------------------------------
	// config registers and effective sizes
	// ------------------------------------------------------------------
	logic [CROP_W-1:0] crop_w_q, crop_h_q;
	logic [OUT_W-1:0]  out_w_q, out_h_q;
	logic [CROP_W-1:0] cw_eff, ch_eff, cwm2, chm2;
	logic [OUT_W-1:0]  ow_eff, oh_eff, h_dvs, v_dvs;

	always_comb begin
		// crop sizes clamp into [2, max]
		if (crop_w_q < CROP_MIN) begin
			cw_eff = CROP_MIN;
		end else if (crop_w_q > CW_MAX) begin
			cw_eff = CW_MAX;
		end else begin
			cw_eff = crop_w_q;
		end
		if (crop_h_q < CROP_MIN) begin
			ch_eff = CROP_MIN;
		end else if (crop_h_q > CH_MAX) begin
			ch_eff = CH_MAX;
		end else begin
			ch_eff = crop_h_q;
		end
		cwm2   = cw_eff - CROP_MIN;
		chm2   = ch_eff - CROP_MIN;
		// zero output size acts as one
		ow_eff = (out_w_q == '0) ? OUT_W'(1) : out_w_q;
		oh_eff = (out_h_q == '0) ? OUT_W'(1) : out_h_q;
		h_dvs  = ow_eff - OUT_W'(1);
		v_dvs  = oh_eff - OUT_W'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crop_w_q <= CROP_W'(128);
			crop_h_q <= CROP_W'(128);
			out_w_q  <= OUT_W'(128);
			out_h_q  <= OUT_W'(128);
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_CROP_W: crop_w_q <= cfg_data[CROP_W-1:0];
				REG_CROP_H: crop_h_q <= cfg_data[CROP_W-1:0];
				REG_OUT_W:  out_w_q  <= cfg_data[OUT_W-1:0];
				REG_OUT_H:  out_h_q  <= cfg_data[OUT_W-1:0];
				default:    crop_w_q <= crop_w_q;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// step divider: ((crop - 2) << 16) / (out - 1), both axes side by side,
	// restoring, msb first; a zero divisor yields a zero step
	// ------------------------------------------------------------------
	logic              div_run_q;
	logic [CNT_W-1:0]  div_cnt_q;
	logic [OUT_W-1:0]  h_rem_q, v_rem_q;
	logic [STEP_W-1:0] hstep_q, vstep_q;
	logic [STEP_W-1:0] h_dvd, v_dvd;
	logic [OUT_W:0]    h_sh, v_sh, h_sub, v_sub;
	logic              h_ge, v_ge, h_qb, v_qb;

	always_comb begin
		h_dvd = {cwm2, {FRAC_W{1'b0}}};
		v_dvd = {chm2, {FRAC_W{1'b0}}};
		h_sh  = {h_rem_q, h_dvd[div_cnt_q]};
		v_sh  = {v_rem_q, v_dvd[div_cnt_q]};
		h_ge  = h_sh >= {1'b0, h_dvs};
		v_ge  = v_sh >= {1'b0, v_dvs};
		h_sub = h_sh - {1'b0, h_dvs};
		v_sub = v_sh - {1'b0, v_dvs};
		h_qb  = h_ge && (h_dvs != '0);
		v_qb  = v_ge && (v_dvs != '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_run_q <= 1'b1;
			div_cnt_q <= CNT_W'(STEP_W - 1);
			h_rem_q   <= '0;
			v_rem_q   <= '0;
		end else if (cfg_we) begin
			// any write restarts both divisions
			div_run_q <= 1'b1;
			div_cnt_q <= CNT_W'(STEP_W - 1);
			h_rem_q   <= '0;
			v_rem_q   <= '0;
		end else if (div_run_q) begin
			h_rem_q <= h_ge ? h_sub[OUT_W-1:0] : h_sh[OUT_W-1:0];
			v_rem_q <= v_ge ? v_sub[OUT_W-1:0] : v_sh[OUT_W-1:0];
			if (div_cnt_q == '0) begin
				div_run_q <= 1'b0;
			end else begin
				div_cnt_q <= div_cnt_q - CNT_W'(1);
			end
		end
	end

	// quotient bits shift in; fully rewritten by the end of a run
	always_ff @(posedge clk) begin
		if (div_run_q) begin
			hstep_q <= {hstep_q[STEP_W-2:0], h_qb};
			vstep_q <= {vstep_q[STEP_W-2:0], v_qb};
		end
	end

	assign busy = div_run_q;

	// ------------------------------------------------------------------
	// stage 1: accept, clamp query coordinates, drop out-of-window loads
	// ------------------------------------------------------------------
	logic              acc;
	logic              ld_in_win;
	logic [POS_W-1:0]  col_c, row_c;
	logic              vld_s1, qry_s1;
	logic [POS_W-1:0]  x_s1, y_s1;
	logic [PIX_W-1:0]  pix_s1;

	always_comb begin
		acc       = start && !busy;
		ld_in_win = (pos_x < {4'b0, cw_eff}) && (pos_y < {4'b0, ch_eff});
		col_c     = ({1'b0, pos_x} < ow_eff) ? pos_x : POS_W'(h_dvs);
		row_c     = ({1'b0, pos_y} < oh_eff) ? pos_y : POS_W'(v_dvs);
	end

	always_ff @(posedge clk) begin
		x_s1   <= mode ? col_c : pos_x;
		y_s1   <= mode ? row_c : pos_y;
		pix_s1 <= pixel_in;
	end

	// ------------------------------------------------------------------
	// stage 2: positions = coordinate * step, load address
	// ------------------------------------------------------------------
	logic                      vld_s2, qry_s2;
	logic [POS_W+STEP_W-1:0]   mx, my;
	logic [31-WGT_LSB:0]       posx_s2, posy_s2;
	logic [2*CROP_W-1:0]       ld_prod;
	logic [2*CROP_W:0]         ld_full;
	logic [AW-1:0]             waddr_s2;
	logic [PIX_W-1:0]          pix_s2;

	always_comb begin
		mx      = x_s1 * hstep_q;
		my      = y_s1 * vstep_q;
		ld_prod = y_s1[CROP_W-1:0] * cw_eff;
		ld_full = {1'b0, ld_prod} + {{(CROP_W+1){1'b0}}, x_s1[CROP_W-1:0]};
	end

	always_ff @(posedge clk) begin
		posx_s2  <= mx[31:WGT_LSB];
		posy_s2  <= my[31:WGT_LSB];
		waddr_s2 <= AW'(ld_full);
		pix_s2   <= pix_s1;
	end

	// ------------------------------------------------------------------
	// stage 3: integer offsets clamped to size - 2, weight pairs
	// ------------------------------------------------------------------
	localparam int OFS_LSB = FRAC_W - WGT_LSB;
	logic [15:0]        ox_raw, oy_raw;
	logic               vld_s3, qry_s3;
	logic [CROP_W-1:0]  ox_s3, oy_s3;
	logic [7:0]         w1_s3, w2_s3, h1_s3, h2_s3;
	logic [AW-1:0]      waddr_s3;
	logic [PIX_W-1:0]   pix_s3;

	always_comb begin
		ox_raw = posx_s2[OFS_LSB+15:OFS_LSB];
		oy_raw = posy_s2[OFS_LSB+15:OFS_LSB];
	end

	always_ff @(posedge clk) begin
		ox_s3    <= (ox_raw > {8'b0, cwm2}) ? cwm2 : ox_raw[CROP_W-1:0];
		oy_s3    <= (oy_raw > {8'b0, chm2}) ? chm2 : oy_raw[CROP_W-1:0];
		w2_s3    <= {1'b0, posx_s2[WGT_W-1:0]};
		w1_s3    <= WGT_ONE - {1'b0, posx_s2[WGT_W-1:0]};
		h2_s3    <= {1'b0, posy_s2[WGT_W-1:0]};
		h1_s3    <= WGT_ONE - {1'b0, posy_s2[WGT_W-1:0]};
		waddr_s3 <= waddr_s2;
		pix_s3   <= pix_s2;
	end

	// ------------------------------------------------------------------
	// stage 4: top-left address a and bottom-left address b = a + pitch
	// ------------------------------------------------------------------
	logic [2*CROP_W-1:0] a_prod;
	logic [2*CROP_W:0]   a_full, b_full;
	logic                vld_s4, qry_s4;
	logic [AW-1:0]       a_s4, b_s4;
	logic [7:0]          w1_s4, w2_s4, h1_s4, h2_s4;
	logic [AW-1:0]       waddr_s4;
	logic [PIX_W-1:0]    pix_s4;

	always_comb begin
		a_prod = oy_s3 * cw_eff;
		a_full = {1'b0, a_prod} + {{(CROP_W+1){1'b0}}, ox_s3};
		b_full = a_full + {{(CROP_W+1){1'b0}}, cw_eff};
	end

	always_ff @(posedge clk) begin
		a_s4     <= AW'(a_full);
		b_s4     <= AW'(b_full);
		w1_s4    <= w1_s3;
		w2_s4    <= w2_s3;
		h1_s4    <= h1_s3;
		h2_s4    <= h2_s3;
		waddr_s4 <= waddr_s3;
		pix_s4   <= pix_s3;
	end

	// ------------------------------------------------------------------
	// frame store: even / odd banks, each one write and two reads a cycle
	// a pair (n, n + 1) always has one word in each bank
	// ------------------------------------------------------------------
	logic [PIX_W-1:0] mem_even_q [BANK_D];
	logic [PIX_W-1:0] mem_odd_q  [BANK_D];
	logic [AW:0]      a_inc, b_inc;
	logic [BI_W-1:0]  idx_et, idx_ot, idx_eb, idx_ob, idx_w;
	logic             wr_en;
	logic [PIX_W-1:0] et_s5, ot_s5, eb_s5, ob_s5;

	always_comb begin
		a_inc  = {1'b0, a_s4} + (AW+1)'(1);
		b_inc  = {1'b0, b_s4} + (AW+1)'(1);
		idx_et = a_inc[AW-1:1];
		idx_ot = a_s4[AW-1:1];
		idx_eb = b_inc[AW-1:1];
		idx_ob = b_s4[AW-1:1];
		idx_w  = waddr_s4[AW-1:1];
		// loads write at the same stage where queries read, so program order holds
		wr_en  = vld_s4 && !qry_s4;
	end

	always_ff @(posedge clk) begin
		if (wr_en && !waddr_s4[0]) begin
			mem_even_q[idx_w] <= pix_s4;
		end
		et_s5 <= mem_even_q[idx_et];
		eb_s5 <= mem_even_q[idx_eb];
	end

	always_ff @(posedge clk) begin
		if (wr_en && waddr_s4[0]) begin
			mem_odd_q[idx_w] <= pix_s4;
		end
		ot_s5 <= mem_odd_q[idx_ot];
		ob_s5 <= mem_odd_q[idx_ob];
	end

	// ------------------------------------------------------------------
	// stage 5: read data back in neighbor order, blend down the rows
	// p1 (row, col), p2 (row + 1, col), p3 (row, col + 1), p4 (row + 1, col + 1)
	// ------------------------------------------------------------------
	logic               vld_s5, swa_s5, swb_s5;
	logic [7:0]         w1_s5, w2_s5, h1_s5, h2_s5;
	logic [PIX_W-1:0]   p1, p2, p3, p4;

	always_ff @(posedge clk) begin
		swa_s5 <= a_s4[0];
		swb_s5 <= b_s4[0];
		w1_s5  <= w1_s4;
		w2_s5  <= w2_s4;
		h1_s5  <= h1_s4;
		h2_s5  <= h2_s4;
	end

	always_comb begin
		p1 = swa_s5 ? ot_s5 : et_s5;
		p3 = swa_s5 ? et_s5 : ot_s5;
		p2 = swb_s5 ? ob_s5 : eb_s5;
		p4 = swb_s5 ? eb_s5 : ob_s5;
	end

	// ------------------------------------------------------------------
	// stage 6: left and right column sums per field
	// ------------------------------------------------------------------
	logic              vld_s6;
	logic [7:0]        w1_s6, w2_s6;
	logic [TOP_W-1:0]  rl_s6, rr_s6, gl_s6, gr_s6, bl_s6, br_s6;

	always_ff @(posedge clk) begin
		rl_s6 <= lerp_h({1'b0, p1[15:11]}, {1'b0, p2[15:11]}, h1_s5, h2_s5);
		rr_s6 <= lerp_h({1'b0, p3[15:11]}, {1'b0, p4[15:11]}, h1_s5, h2_s5);
		gl_s6 <= lerp_h(p1[10:5], p2[10:5], h1_s5, h2_s5);
		gr_s6 <= lerp_h(p3[10:5], p4[10:5], h1_s5, h2_s5);
		bl_s6 <= lerp_h({1'b0, p1[4:0]}, {1'b0, p2[4:0]}, h1_s5, h2_s5);
		br_s6 <= lerp_h({1'b0, p3[4:0]}, {1'b0, p4[4:0]}, h1_s5, h2_s5);
		w1_s6 <= w1_s5;
		w2_s6 <= w2_s5;
	end

	// ------------------------------------------------------------------
	// stage 7: blend across columns, >> 14, pack rgb565 into the output reg
	// ------------------------------------------------------------------
	logic             vld_s7;
	logic [PIX_W-1:0] pix_s7;
	logic [5:0]       r_v, g_v, b_v;

	always_comb begin
		r_v = lerp_v(rl_s6, rr_s6, w1_s6, w2_s6);
		g_v = lerp_v(gl_s6, gr_s6, w1_s6, w2_s6);
		b_v = lerp_v(bl_s6, br_s6, w1_s6, w2_s6);
	end

	always_ff @(posedge clk) begin
		pix_s7 <= {r_v[4:0], g_v, b_v[4:0]};
	end

	// valid bits; only queries travel past the store
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			qry_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			qry_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			qry_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			qry_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
		end else begin
			vld_s1 <= acc && (mode || ld_in_win);
			qry_s1 <= mode;
			vld_s2 <= vld_s1;
			qry_s2 <= qry_s1;
			vld_s3 <= vld_s2;
			qry_s3 <= qry_s2;
			vld_s4 <= vld_s3;
			qry_s4 <= qry_s3;
			vld_s5 <= vld_s4 && qry_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
		end
	end

	assign pixel_valid = vld_s7;
	assign pixel_out   = pix_s7;

	// ------------------------------------------------------------------
	// assertions
	// ------------------------------------------------------------------
	a_result_from_query : assert property (@(posedge clk) disable iff (!arst_n)
		pixel_valid |-> $past(start && !busy && mode, 7))
		else $error("result beat without a query seven cycles earlier");

	a_load_no_result : assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && !mode) |-> ##7 !pixel_valid)
		else $error("load beat produced a result");

	a_cfg_restarts_div : assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> busy)
		else $error("config write did not restart the step divider");

	a_unit_width_zero_step : assert property (@(posedge clk) disable iff (!arst_n)
		($fell(busy) && (out_w_q <= OUT_W'(1))) |-> (hstep_q == '0))
		else $error("single-column output has a nonzero horizontal step");

	a_unit_height_zero_step : assert property (@(posedge clk) disable iff (!arst_n)
		($fell(busy) && (out_h_q <= OUT_W'(1))) |-> (vstep_q == '0))
		else $error("single-row output has a nonzero vertical step");

endmodule
